/* hdl/sem_pkg.sv */
// ----------------------------------------------------------------------------
// sem_pkg
// shared types and constants of the sobel edge magnitude block
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_DIM    = 3;

   localparam int DIM_W   = 13;
   localparam int COORD_W = $clog2(MAX_WIDTH);
   localparam int PIX_W   = 8;
   localparam int SUMSQ_W = 21;
   localparam int ROOT_W  = 8;
   localparam int STEP_W  = $clog2(ROOT_W);

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_ROOT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } root_status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                  input logic [DIM_W-1:0] upper);
      logic [DIM_W-1:0] result;
      result = value;
      if (value < DIM_W'(MIN_DIM)) begin
         result = DIM_W'(MIN_DIM);
      end else if (value > upper) begin
         result = upper;
      end
      return result;
   endfunction

endpackage

/* hdl/sobel_edge_magnitude_top.sv */
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_top
// 3x3 sobel gradient magnitude over a raster grayscale pixel stream
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one word per handshake. For each pixel its
// column is read from the two line memories, then the window is formed, the
// column is written back and the counters advance. A pixel at column two or
// more and row two or more produces a result for the window center; the
// eight-step square root unit then runs, and the next word is taken only once
// the root is done and the output register is free. Border pixels give
// no result. A finished result waits in an output register while the next
// pixel is taken. frame_width and frame_height are clamped to 3..4096.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_top
   import sem_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [PIX_W-1:0]   req_pixel,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ROOT_W-1:0]  rsp_magnitude,
   output logic [COORD_W-1:0] rsp_out_col,
   output logic [COORD_W-1:0] rsp_out_row,
   output logic               rsp_frame_done,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [DIM_W-1:0]   csr_data
);

   state_type state_ff, state_in;

   logic [DIM_W-1:0]   width_ff, height_ff;
   logic [COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [PIX_W-1:0]   pixel_ff, pixel_in;
   logic [COORD_W-1:0] cen_col_ff, cen_col_in, cen_row_ff, cen_row_in;
   logic               cen_done_ff, cen_done_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0]  rsp_mag_ff, rsp_mag_in;
   logic [COORD_W-1:0] rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;
   logic               rsp_done_ff, rsp_done_in;

   logic [DIM_W-1:0]   width_eff, height_eff;
   logic               end_row, end_frame, interior;
   logic               wr_en, shift_en, root_start, out_free;
   logic [PIX_W-1:0]   top_pix, mid_pix;
   logic [SUMSQ_W-1:0] sumsq;
   logic [ROOT_W-1:0]  root;
   root_status_type    root_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: height_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign width_eff  = clamp_dim(width_ff, DIM_W'(MAX_WIDTH));
   assign height_eff = clamp_dim(height_ff, DIM_W'(MAX_HEIGHT));
   assign end_row    = DIM_W'(col_ff) >= width_eff - DIM_W'(1);
   assign end_frame  = end_row && (DIM_W'(row_ff) >= height_eff - DIM_W'(1));
   assign interior   = (col_ff >= COORD_W'(2)) && (row_ff >= COORD_W'(2));
   assign out_free   = !rsp_valid_ff || rsp_ready;

   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_above (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (col_ff),
      .wr_data (pixel_ff),
      .rd_addr (col_ff),
      .rd_data (mid_pix)
   );

   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_two_above (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (col_ff),
      .wr_data (mid_pix),
      .rd_addr (col_ff),
      .rd_data (top_pix)
   );

   sem_grad u_grad (
      .clock    (clock),
      .reset    (reset),
      .shift_en (shift_en),
      .top      (top_pix),
      .mid      (mid_pix),
      .bot      (pixel_ff),
      .sumsq    (sumsq)
   );

   sem_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (root_start),
      .value  (sumsq),
      .status (root_status),
      .root   (root)
   );

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pixel_in     = pixel_ff;
      cen_col_in   = cen_col_ff;
      cen_row_in   = cen_row_ff;
      cen_done_in  = cen_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_mag_in   = rsp_mag_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_done_in  = rsp_done_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      shift_en     = 1'b0;
      root_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               pixel_in = req_pixel;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            wr_en       = 1'b1;
            shift_en    = 1'b1;
            cen_col_in  = col_ff - COORD_W'(1);
            cen_row_in  = row_ff - COORD_W'(1);
            cen_done_in = end_frame;
            if (end_row) begin
               col_in = '0;
               row_in = end_frame ? '0 : row_ff + COORD_W'(1);
            end else begin
               col_in = col_ff + COORD_W'(1);
            end
            if (interior) begin
               root_start = 1'b1;
               state_in   = ST_ROOT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ROOT: begin
            if (root_status.done && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mag_in   = root;
               rsp_col_in   = cen_col_ff;
               rsp_row_in   = cen_row_ff;
               rsp_done_in  = cen_done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pixel_ff    <= pixel_in;
      cen_col_ff  <= cen_col_in;
      cen_row_ff  <= cen_row_in;
      cen_done_ff <= cen_done_in;
      rsp_mag_ff  <= rsp_mag_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_magnitude  = rsp_mag_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_frame_done = rsp_done_ff;

   a_read_after_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> $past(req_valid && req_ready))
      else $error("line memory read state without accepted word");

   a_root_only_in_root: assert property (@(posedge clock) disable iff (reset)
      root_status.busy |-> state_ff == ST_ROOT)
      else $error("square root busy outside root state");

   a_rsp_from_root: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_ROOT && root_status.done))
      else $error("result word loaded without finished root");

endmodule

/* hdl/sem_ram.sv */
// ----------------------------------------------------------------------------
// sem_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/sem_grad.sv */
// ----------------------------------------------------------------------------
// sem_grad
// 3x3 window columns and sobel gradient, gx squared plus gy squared
// ----------------------------------------------------------------------------
module sem_grad
   import sem_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               shift_en,
   input  logic [PIX_W-1:0]   top,
   input  logic [PIX_W-1:0]   mid,
   input  logic [PIX_W-1:0]   bot,
   output logic [SUMSQ_W-1:0] sumsq
);

   logic [PIX_W-1:0] win_ff [6];
   logic [PIX_W-1:0] win_in [6];

   logic [PIX_W+1:0]  right_sum, left_sum, lower_sum, upper_sum;
   logic signed [PIX_W+2:0] gx, gy;
   logic signed [2*PIX_W+5:0] gx_sq, gy_sq;

   always_comb begin
      win_in = win_ff;
      if (shift_en) begin
         win_in[0] = win_ff[3];
         win_in[1] = win_ff[4];
         win_in[2] = win_ff[5];
         win_in[3] = top;
         win_in[4] = mid;
         win_in[5] = bot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         win_ff <= win_in;
      end
   end

   // left column tl ml bl, middle column tm - bm
   always_comb begin
      right_sum = (PIX_W+2)'(top) + {1'b0, mid, 1'b0} + (PIX_W+2)'(bot);
      left_sum  = (PIX_W+2)'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + (PIX_W+2)'(win_ff[2]);
      lower_sum = (PIX_W+2)'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + (PIX_W+2)'(bot);
      upper_sum = (PIX_W+2)'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + (PIX_W+2)'(top);
      gx = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
      gy = $signed({1'b0, lower_sum}) - $signed({1'b0, upper_sum});
      gx_sq = gx * gx;
      gy_sq = gy * gy;
      sumsq = gx_sq[SUMSQ_W-1:0] + gy_sq[SUMSQ_W-1:0];
   end

endmodule

/* hdl/sem_isqrt.sv */
// ----------------------------------------------------------------------------
// sem_isqrt
// iterative floor square root, one result bit per cycle, saturates at 255
// ----------------------------------------------------------------------------
module sem_isqrt
   import sem_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUMSQ_W-1:0] value,
   output root_status_type    status,
   output logic [ROOT_W-1:0]  root
);

   logic [2*ROOT_W-1:0] value_ff, value_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                sat_ff, sat_in;
   logic [ROOT_W-1:0]   trial;
   logic [2*ROOT_W-1:0] trial_sq;

   always_comb begin
      value_in = value_ff;
      root_in  = root_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      sat_in   = sat_ff;
      trial    = root_ff | (ROOT_W'(1) << step_ff);
      trial_sq = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);
      if (start) begin
         value_in = value[2*ROOT_W-1:0];
         sat_in   = |value[SUMSQ_W-1:2*ROOT_W];
         root_in  = '0;
         step_in  = STEP_W'(ROOT_W-1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (trial_sq <= value_ff) begin
            root_in = trial;
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      value_ff <= value_in;
      root_ff  <= root_in;
      step_ff  <= step_in;
      sat_ff   <= sat_in;
   end

   assign status.busy = busy_ff;
   assign status.done = !busy_ff;
   assign root = sat_ff ? '1 : root_ff;

endmodule

/* dv/tb_sobel_edge_magnitude_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_top
// self-checking bench for the 3x3 sobel gradient magnitude block
// ----------------------------------------------------------------------------
// Streams raster frames into the block and checks every magnitude word,
// with its coordinates and frame end mark, against a local model of the line
// stores, the window and the counters. Runs the reset frame width, a short
// table of flat and hard-edge frames, sub-range sizes, mid-frame size updates,
// and random frames under sender idling, receiver stalls and a long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_top
   import sem_pkg::*;
();

   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 5000;
   localparam int PHASE_PIXELS  = 270;
   localparam int SQUARE_LIMIT  = 65536;

   typedef struct packed {
      logic [ROOT_W-1:0]  magnitude;
      logic [COORD_W-1:0] out_col;
      logic [COORD_W-1:0] out_row;
      logic               frame_done;
   } magnitude_word_type;

   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {TEX_NOISE, TEX_SMOOTH, TEX_BINARY} texture_type;

   typedef struct {
      row_kind_type       kind;
      logic               reg_index;
      logic [DIM_W-1:0]   value;
      logic               typed;
      magnitude_word_type want;
   } stim_row_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   logic [PIX_W-1:0]   req_pixel      = '0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic [ROOT_W-1:0]  rsp_magnitude;
   logic [COORD_W-1:0] rsp_out_col;
   logic [COORD_W-1:0] rsp_out_row;
   logic               rsp_frame_done;
   logic               csr_valid      = 1'b0;
   logic               csr_ready;
   logic               csr_index      = 1'b0;
   logic [DIM_W-1:0]   csr_data       = '0;

   // local model state
   logic [PIX_W-1:0]   line_above     [MAX_WIDTH] = '{default: '0};
   logic [PIX_W-1:0]   line_two_above [MAX_WIDTH] = '{default: '0};
   logic [PIX_W-1:0]   left_col       [3]         = '{default: '0};
   logic [PIX_W-1:0]   center_col     [3]         = '{default: '0};
   int                 col_at         = 0;
   int                 row_at         = 0;
   logic [DIM_W-1:0]   width_reg      = WIDTH_RESET;
   logic [DIM_W-1:0]   height_reg     = HEIGHT_RESET;

   magnitude_word_type pending_magnitudes [$];
   stim_row_type       stim_table [$];

   int   idle_plan  [4] = '{0, 68, 0, 35};
   int   stall_plan [4] = '{0, 0, 68, 35};
   int   send_idle_pct  = 0;
   int   stall_pct      = 0;
   int   hold_asks      = 0;
   int   hold_seen      = 0;
   int   hold_left      = 0;
   int   quiet_cycles   = 0;

   int   mismatch_count = 0;
   int   pixels_sent    = 0;
   int   csr_writes     = 0;
   int   words_checked  = 0;
   int   saturated_seen = 0;
   int   frame_ends     = 0;

   sobel_edge_magnitude_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_done (rsp_frame_done),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int dim_limit(input logic [DIM_W-1:0] raw, input int upper);
      if (raw < MIN_DIM) return MIN_DIM;
      if (raw > upper) return upper;
      return int'(raw);
   endfunction

   function automatic int floor_root(input int value);
      int root;
      int trial;
      root = 0;
      for (int bit_pos = ROOT_W - 1; bit_pos >= 0; bit_pos--) begin
         trial = root | (1 << bit_pos);
         if (trial * trial <= value) root = trial;
      end
      return root;
   endfunction

   task automatic predict_magnitude(input logic [PIX_W-1:0] pix, output logic produced,
                                    output magnitude_word_type word);
      int   w, h, idx, t, m, b, gx, gy, sumsq, mag;
      logic end_row, end_frame;
      w         = dim_limit(width_reg, MAX_WIDTH);
      h         = dim_limit(height_reg, MAX_HEIGHT);
      idx       = (col_at < MAX_WIDTH) ? col_at : MAX_WIDTH - 1;
      t         = line_two_above[idx];
      m         = line_above[idx];
      b         = pix;
      end_row   = (col_at >= w - 1);
      end_frame = end_row && (row_at >= h - 1);
      produced  = (col_at >= 2) && (row_at >= 2);
      word      = '0;
      if (produced) begin
         gx = (t + 2 * m + b) - (left_col[0] + 2 * left_col[1] + left_col[2]);
         gy = (left_col[2] + 2 * center_col[2] + b) - (left_col[0] + 2 * center_col[0] + t);
         sumsq = gx * gx + gy * gy;
         mag = (sumsq >= SQUARE_LIMIT) ? 255 : floor_root(sumsq);
         word.magnitude  = ROOT_W'(mag);
         word.out_col    = COORD_W'(col_at - 1);
         word.out_row    = COORD_W'(row_at - 1);
         word.frame_done = end_frame;
      end
      left_col            = center_col;
      center_col          = '{PIX_W'(t), PIX_W'(m), pix};
      line_two_above[idx] = PIX_W'(m);
      line_above[idx]     = pix;
      if (end_row) begin
         col_at = 0;
         row_at = end_frame ? 0 : row_at + 1;
      end else begin
         col_at = col_at + 1;
      end
   endtask

   task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                             input magnitude_word_type want);
      logic               produced;
      magnitude_word_type word;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_magnitude(pix, produced, word);
      if (typed) pending_magnitudes.push_back(want);
      else if (produced) pending_magnitudes.push_back(word);
      pixels_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_magnitudes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic index, input logic [DIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == CSR_FRAME_WIDTH) width_reg = value;
      else height_reg = value;
      csr_writes++;
   endtask

   task automatic configure(input int w_raw, input int h_raw);
      wait_idle();
      if ($urandom_range(1)) begin
         csr_write(CSR_FRAME_WIDTH, DIM_W'(w_raw));
         csr_write(CSR_FRAME_HEIGHT, DIM_W'(h_raw));
      end else begin
         csr_write(CSR_FRAME_HEIGHT, DIM_W'(h_raw));
         csr_write(CSR_FRAME_WIDTH, DIM_W'(w_raw));
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [PIX_W-1:0] frame_pixel(input texture_type tex, input int base);
      case (tex)
         TEX_SMOOTH: return PIX_W'(base + $urandom_range(31));
         TEX_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
         default:    return PIX_W'($urandom_range(255));
      endcase
   endfunction

   // mid-frame updates only shrink the width so no stale column is read
   task automatic run_frame(input int w_raw, input int h_raw, input bit mid_change,
                            input texture_type tex, input bit hold);
      int cut, sent, base;
      configure(w_raw, h_raw);
      if (hold) hold_asks <= hold_asks + 1;
      cut  = $urandom_range(1, dim_limit(DIM_W'(w_raw), MAX_WIDTH)
                               * dim_limit(DIM_W'(h_raw), MAX_HEIGHT) - 1);
      base = $urandom_range(224);
      sent = 0;
      do begin
         push_pixel(frame_pixel(tex, base), 1'b0, '0);
         sent++;
         if (mid_change && sent == cut) begin
            configure($urandom_range(0, dim_limit(width_reg, MAX_WIDTH)), $urandom_range(0, 10));
         end
      end while (col_at != 0 || row_at != 0);
   endtask

   function automatic stim_row_type csr_row(input logic index, input int value);
      stim_row_type row;
      row.kind      = ROW_CSR;
      row.reg_index = index;
      row.value     = DIM_W'(value);
      row.typed     = 1'b0;
      row.want      = '0;
      return row;
   endfunction

   function automatic stim_row_type pixel_row(input int value, input logic typed,
                                              input magnitude_word_type want);
      stim_row_type row;
      row.kind      = ROW_PIXEL;
      row.reg_index = CSR_FRAME_WIDTH;
      row.value     = DIM_W'(value);
      row.typed     = typed;
      row.want      = want;
      return row;
   endfunction

   task automatic log_mismatch(input string what);
      if (mismatch_count < 40) $display("mismatch: %s", what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      magnitude_word_type got;
      magnitude_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_magnitude, rsp_out_col, rsp_out_row, rsp_frame_done};
         if (pending_magnitudes.size() == 0) begin
            log_mismatch($sformatf("unexpected word mag %0d col %0d row %0d done %0b",
                                   got.magnitude, got.out_col, got.out_row, got.frame_done));
         end else begin
            want = pending_magnitudes.pop_front();
            if (got.magnitude !== want.magnitude)
               log_mismatch($sformatf("magnitude %0d, want %0d at col %0d row %0d",
                                      got.magnitude, want.magnitude, want.out_col, want.out_row));
            if (got.out_col !== want.out_col)
               log_mismatch($sformatf("out_col %0d, want %0d", got.out_col, want.out_col));
            if (got.out_row !== want.out_row)
               log_mismatch($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
            if (got.frame_done !== want.frame_done)
               log_mismatch($sformatf("frame_done %0b, want %0b at col %0d row %0d",
                                      got.frame_done, want.frame_done,
                                      want.out_col, want.out_row));
         end
         words_checked++;
         if (got.magnitude == 8'hFF) saturated_seen++;
         if (got.frame_done) frame_ends++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d words pending",
                  quiet_cycles, pending_magnitudes.size());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int          phase_goal;
      int          w_raw;
      int          h_raw;
      bit          lead_frame;
      texture_type tex;

      // flat frame at the smallest size
      stim_table.push_back(csr_row(CSR_FRAME_WIDTH, 3));
      stim_table.push_back(csr_row(CSR_FRAME_HEIGHT, 3));
      repeat (8) stim_table.push_back(pixel_row(0, 1'b0, '0));
      stim_table.push_back(pixel_row(0, 1'b1, {8'd0, 12'd1, 12'd1, 1'b1}));
      // dark left column, bright right column
      for (int r = 0; r < 3; r++) begin
         stim_table.push_back(pixel_row(0, 1'b0, '0));
         stim_table.push_back(pixel_row(0, 1'b0, '0));
         stim_table.push_back(pixel_row(255, r == 2, {8'd255, 12'd1, 12'd1, 1'b1}));
      end
      // sizes below range, dark top row, bright bottom row
      stim_table.push_back(csr_row(CSR_FRAME_WIDTH, 1));
      stim_table.push_back(csr_row(CSR_FRAME_HEIGHT, 2));
      repeat (3) stim_table.push_back(pixel_row(0, 1'b0, '0));
      repeat (3) stim_table.push_back(pixel_row(128, 1'b0, '0));
      repeat (2) stim_table.push_back(pixel_row(255, 1'b0, '0));
      stim_table.push_back(pixel_row(255, 1'b1, {8'd255, 12'd1, 12'd1, 1'b1}));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset frame width: one full row and the first word of the next
      for (int n = 0; n < int'(WIDTH_RESET) + 1; n++) begin
         push_pixel(PIX_W'($urandom_range(255)), 1'b0, '0);
      end
      // shrink mid-frame so the row closes and one more row ends the frame
      configure(3, 3);
      repeat (5) push_pixel(PIX_W'($urandom_range(255)), 1'b0, '0);

      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CSR) begin
            if (i == 0 || stim_table[i-1].kind != ROW_CSR) wait_idle();
            csr_write(stim_table[i].reg_index, stim_table[i].value);
            if (i == stim_table.size() - 1 || stim_table[i+1].kind != ROW_CSR)
               csr_valid <= 1'b0;
         end else begin
            push_pixel(stim_table[i].value[PIX_W-1:0], stim_table[i].typed,
                       stim_table[i].want);
         end
      end

      for (int ph = 0; ph < 4; ph++) begin
         phase_goal = pixels_sent + PHASE_PIXELS;
         lead_frame = 1'b1;
         while (pixels_sent < phase_goal) begin
            send_idle_pct = ($urandom_range(3) == 0) ? 0 : idle_plan[ph];
            stall_pct     = ($urandom_range(3) == 0) ? 0 : stall_plan[ph];
            tex           = texture_type'($urandom_range(2));
            if (lead_frame) begin
               w_raw = 12;
               h_raw = 8;
            end else begin
               w_raw = ($urandom_range(5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
               h_raw = ($urandom_range(5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            end
            run_frame(w_raw, h_raw, $urandom_range(4) == 0, tex, lead_frame);
            lead_frame = 1'b0;
         end
      end

      wait_idle();
      $display("covered %0d pixels and %0d register writes: reset width, sub-range clamps,",
               pixels_sent, csr_writes);
      $display("mid-frame sizes and stalls; %0d words checked, %0d saturated, %0d frame ends",
               words_checked, saturated_seen, frame_ends);
      if (mismatch_count == 0 && pending_magnitudes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/sem_pkg.sv
hdl/sem_ram.sv
hdl/sem_grad.sv
hdl/sem_isqrt.sv
hdl/sobel_edge_magnitude_top.sv
dv/tb_sobel_edge_magnitude_top.sv
